>>> rtl/rbc_pkg.sv
package rbc_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned DigitSlots = 11;
   localparam int unsigned DecSlots   = 10;
   localparam int unsigned OctSlots   = 11;
   localparam int unsigned HexSlots   = 8;
   localparam int unsigned DigitBits  = 4 * DigitSlots;

   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharAlpha = 8'h37;

   typedef enum logic [1:0] {
      OP_SDEC = 2'd0,
      OP_UDEC = 2'd1,
      OP_OCT  = 2'd2,
      OP_HEX  = 2'd3
   } opcode_type;

   typedef enum logic {
      CONV_IDLE,
      CONV_SHIFT
   } conv_state_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_SIGN,
      EMIT_DIGIT,
      EMIT_SPACE
   } emit_state_type;

   // digits are left aligned: the top slots nibbles hold the number, msd first
   typedef struct packed {
      logic                 valid;
      logic                 neg;
      logic [3:0]           slots;
      logic [DigitBits-1:0] digits;
   } conv_result_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] code;
      if (d < 4'd10) begin
         code = CharZero + {4'b0000, d};
      end else begin
         code = CharAlpha + {4'b0000, d};
      end
      return code;
   endfunction

endpackage

>>> rtl/rbc_dabble.sv
module rbc_dabble (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [31:0]               value,
   input  logic [1:0]                opcode,
   output rbc_pkg::conv_result_type  result
);

   rbc_pkg::conv_state_type state_ff, state_in;
   logic [31:0]                    mag_ff, mag_in;
   logic [4:0]                     count_ff, count_in;
   logic [rbc_pkg::DigitBits-1:0]  digits_ff, digits_in;
   logic                           neg_ff, neg_in;
   logic [3:0]                     slots_ff, slots_in;
   logic                           done_ff, done_in;

   logic [39:0]                    adj;
   logic [rbc_pkg::DigitBits-1:0]  oct_digits;
   logic [32:0]                    oct_padded;
   logic                           is_neg;
   logic [31:0]                    magnitude;

   always_comb begin
      for (int i = 0; i < 10; i++) begin
         if (digits_ff[4 + 4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = digits_ff[4 + 4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = digits_ff[4 + 4*i +: 4];
         end
      end
   end

   assign oct_padded = {1'b0, value};
   always_comb begin
      for (int i = 0; i < rbc_pkg::DigitSlots; i++) begin
         oct_digits[4*i +: 4] = {1'b0, oct_padded[3*i +: 3]};
      end
   end

   // 0x80000000 negates to itself, which is 2^31 read unsigned
   assign is_neg    = (rbc_pkg::opcode_type'(opcode) == rbc_pkg::OP_SDEC) && value[31];
   assign magnitude = is_neg ? (32'd0 - value) : value;

   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      count_in  = count_ff;
      digits_in = digits_ff;
      neg_in    = neg_ff;
      slots_in  = slots_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         rbc_pkg::CONV_IDLE: begin
            if (start) begin
               neg_in = is_neg;
               unique case (rbc_pkg::opcode_type'(opcode)) inside
                  rbc_pkg::OP_SDEC, rbc_pkg::OP_UDEC: begin
                     mag_in    = magnitude;
                     digits_in = '0;
                     count_in  = '1;
                     slots_in  = 4'(rbc_pkg::DecSlots);
                     state_in  = rbc_pkg::CONV_SHIFT;
                  end
                  rbc_pkg::OP_OCT: begin
                     digits_in = oct_digits;
                     slots_in  = 4'(rbc_pkg::OctSlots);
                     done_in   = 1'b1;
                  end
                  rbc_pkg::OP_HEX: begin
                     digits_in = {value, 12'h000};
                     slots_in  = 4'(rbc_pkg::HexSlots);
                     done_in   = 1'b1;
                  end
                  default: begin
                     done_in = 1'b0;
                  end
               endcase
            end
         end
         rbc_pkg::CONV_SHIFT: begin
            // double dabble: correct each bcd digit, then shift one binary bit in
            digits_in = {adj[38:0], mag_ff[31], 4'h0};
            mag_in    = {mag_ff[30:0], 1'b0};
            count_in  = count_ff - 5'd1;
            if (count_ff == 5'd0) begin
               state_in = rbc_pkg::CONV_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = rbc_pkg::CONV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbc_pkg::CONV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      count_ff  <= count_in;
      digits_ff <= digits_in;
      neg_ff    <= neg_in;
      slots_ff  <= slots_in;
   end

   assign result.valid  = done_ff;
   assign result.neg    = neg_ff;
   assign result.slots  = slots_ff;
   assign result.digits = digits_ff;

endmodule

>>> rtl/rbc_emit.sv
module rbc_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  rbc_pkg::conv_result_type  result,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_character,
   output logic                      rsp_last,
   output logic                      finish
);

   rbc_pkg::emit_state_type        state_ff, state_in;
   logic [rbc_pkg::DigitBits-1:0]  digits_ff, digits_in;
   logic [3:0]                     slots_ff, slots_in;
   logic                           started_ff, started_in;
   logic                           valid_ff, valid_in;
   logic [7:0]                     char_ff, char_in;
   logic                           last_ff, last_in;

   logic                           free;
   logic [3:0]                     nib;
   logic                           last_slot;

   assign free      = !valid_ff || !rsp_stall;
   assign nib       = digits_ff[rbc_pkg::DigitBits-1 -: 4];
   assign last_slot = (slots_ff == 4'd1);

   always_comb begin
      state_in   = state_ff;
      digits_in  = digits_ff;
      slots_in   = slots_ff;
      started_in = started_ff;
      valid_in   = valid_ff && rsp_stall;
      char_in    = char_ff;
      last_in    = last_ff;
      finish     = 1'b0;
      unique case (state_ff)
         rbc_pkg::EMIT_IDLE: begin
            if (result.valid) begin
               digits_in  = result.digits;
               slots_in   = result.slots;
               started_in = 1'b0;
               state_in   = result.neg ? rbc_pkg::EMIT_SIGN : rbc_pkg::EMIT_DIGIT;
            end
         end
         rbc_pkg::EMIT_SIGN: begin
            if (free) begin
               valid_in = 1'b1;
               char_in  = rbc_pkg::CharMinus;
               last_in  = 1'b0;
               state_in = rbc_pkg::EMIT_DIGIT;
            end
         end
         rbc_pkg::EMIT_DIGIT: begin
            if (free) begin
               // leading zeros are dropped, but the final slot always goes out
               if (started_ff || (nib != 4'h0) || last_slot) begin
                  valid_in   = 1'b1;
                  char_in    = rbc_pkg::digit_char(nib);
                  last_in    = 1'b0;
                  started_in = 1'b1;
               end
               digits_in = {digits_ff[rbc_pkg::DigitBits-5:0], 4'h0};
               slots_in  = slots_ff - 4'd1;
               if (last_slot) begin
                  state_in = rbc_pkg::EMIT_SPACE;
               end
            end
         end
         rbc_pkg::EMIT_SPACE: begin
            if (free) begin
               valid_in = 1'b1;
               char_in  = rbc_pkg::CharSpace;
               last_in  = 1'b1;
               finish   = 1'b1;
               state_in = rbc_pkg::EMIT_IDLE;
            end
         end
         default: begin
            state_in = rbc_pkg::EMIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbc_pkg::EMIT_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff  <= digits_in;
      slots_ff   <= slots_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

>>> rtl/binary_to_ascii_radix_converter_top.sv
// Converts a 32-bit word to ASCII text, one character per rsp beat, most significant
// digit first with no leading zeros, a '-' ahead of a negative signed decimal value,
// upper case hex and a trailing space flagged by rsp_last. One word is in flight at a
// time. Hex and octal words go straight to the emitter with 8 and 11 digit slots;
// decimal words first run the bit-serial double dabble loop and then give 10 digit
// slots. A stall on the rsp side holds the current beat until it is taken.
module binary_to_ascii_radix_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   input  logic [1:0]  req_opcode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   logic                      busy_ff, busy_in;
   logic                      accept;
   logic                      finish;
   rbc_pkg::conv_result_type  conv_result;

   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   rbc_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .value  (req_value),
      .opcode (req_opcode),
      .result (conv_result)
   );

   rbc_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .result        (conv_result),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .finish        (finish)
   );

endmodule

>>> rtl/rbc_checker.sv
module rbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_value,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_character,
   input logic        rsp_last
);

   // a held request beat keeps its word and mode
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_value) && $stable(req_opcode))
      else $error("req beat changed while stalled");

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // one word at a time: the request side closes straight after a beat is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while one is in flight");

   a_last_is_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_character == 8'h20)
      else $error("closing beat is not a space");

   a_space_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_character != 8'h20)
      else $error("space seen before the closing beat");

endmodule

bind binary_to_ascii_radix_converter_top rbc_checker u_rbc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_value     (req_value),
   .req_opcode    (req_opcode),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);
